FILE: rtl/kvdp_pkg.sv
// kvdp_pkg: shared types, widths, character codes and scale table for the
// key/value decimal parser. No dependencies.
package kvdp_pkg;

    localparam int CH_W                = 8;
    localparam int VALUE_W             = 48;
    localparam int INT_W               = 27;
    localparam int FRAC_W              = 20;
    localparam int CNT_W               = 3;
    localparam int MAX_FRACTION_DIGITS = 6;
    localparam int ACC_W               = 30;   // integer_part * 10 + 9 before clamp

    localparam logic [INT_W-1:0]  INT_LIMIT = INT_W'(99999999);
    localparam logic [FRAC_W-1:0] MICRO     = FRAC_W'(1000000);
    localparam logic [CNT_W-1:0]  FRAC_MAX  = CNT_W'(MAX_FRACTION_DIGITS);

    localparam logic [CH_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CH_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CHAR_DOT   = 8'd46;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CHAR_COLON = 8'd58;

    typedef enum logic [2:0] {
        PH_SEEK_COLON  = 3'd0,
        PH_SEEK_NUMBER = 3'd1,
        PH_AFTER_MINUS = 3'd2,
        PH_INTEGER     = 3'd3,
        PH_FRACTION    = 3'd4,
        PH_DONE        = 3'd5
    } t_phase;

    // finished number handed from the parser to the scaler
    typedef struct packed {
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_digits;
        logic [CNT_W-1:0]  frac_count;
        logic              negative;
    } t_num;

    // weight of the fraction digits: 10^(6 - count)
    function automatic logic [FRAC_W-1:0] frac_scale(input logic [CNT_W-1:0] cnt);
        logic [FRAC_W-1:0] s;
        begin
            case (cnt)
                3'd0:    s = FRAC_W'(1000000);
                3'd1:    s = FRAC_W'(100000);
                3'd2:    s = FRAC_W'(10000);
                3'd3:    s = FRAC_W'(1000);
                3'd4:    s = FRAC_W'(100);
                3'd5:    s = FRAC_W'(10);
                default: s = FRAC_W'(1);
            endcase
            return s;
        end
    endfunction

endpackage

FILE: rtl/kvdp_in_if.sv
// kvdp_in_if: byte input channel (valid/ready plus one text byte).
// Depends on kvdp_pkg.
interface kvdp_in_if;
    logic                      valid;
    logic                      ready;
    logic [kvdp_pkg::CH_W-1:0] ch;
    logic                      start_of_text;

    modport source (output valid, output ch, output start_of_text, input ready);
    modport sink   (input valid, input ch, input start_of_text, output ready);
endinterface

FILE: rtl/kvdp_out_if.sv
// kvdp_out_if: result channel (valid/ready plus signed value in millionths).
// Depends on kvdp_pkg.
interface kvdp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kvdp_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/key_value_decimal_parser_core.sv
// key_value_decimal_parser_core: top level of the key/value decimal parser.
// Depends on kvdp_pkg, kvdp_in_if, kvdp_out_if, kvdp_parse, kvdp_scale.
//
//  port    dir  modport  payload                       meaning
//  i_in    in   sink     ch[7:0], start_of_text        one text byte per transaction
//  o_out   out  source   value[47:0] signed            number in millionths, at most one per text
//
// One byte per cycle sustained while i_in.ready is high. A byte is folded
// into the parse state in the cycle it is accepted (multiply-by-ten plus
// saturate). The ending byte loads the number register; the result then
// moves on through the multiply stage into the result register.
// Reset (i_rst_n low, synchronous) clears the parse to "seek colon" and
// empties every stage. Each stage moves when the one after it is empty or
// draining, so input keeps flowing while a result waits on o_out.ready;
// i_in.ready drops only once all three stages hold a number.
module key_value_decimal_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kvdp_in_if.sink     i_in,
    kvdp_out_if.source  o_out
);
    import kvdp_pkg::*;

    // finished-number transaction, parser to scaler
    logic num_valid;
    logic num_ready;
    t_num num;

    kvdp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_num_valid (num_valid),
        .i_num_ready (num_ready),
        .o_num       (num)
    );

    kvdp_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_valid (num_valid),
        .o_num_ready (num_ready),
        .i_num       (num),
        .o_out       (o_out)
    );

    // input stalls only with a full pipeline, so a result must be showing
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no result pending");

    // a NUL that opens a new text always ends it
    a_nul_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.start_of_text && (i_in.ch == CHAR_NUL))
        |=> num_valid)
        else $error("NUL at start of text gave no number");

    // magnitude never exceeds 99999999.999999
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.value <= 48'sd99999999999999) &&
                         (o_out.value >= -48'sd99999999999999)))
        else $error("result out of range");

    // a number sitting in the stage register leaves it only toward the scaler
    a_num_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (num_valid && !num_ready) |=> (num_valid && $stable(num)))
        else $error("number lost between parser and scaler");

endmodule

FILE: rtl/kvdp_parse.sv
// kvdp_parse: per-byte parse state machine and number output register.
// Depends on kvdp_pkg, kvdp_in_if.
module kvdp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    kvdp_in_if.sink             i_in,
    output logic                o_num_valid,
    input  logic                i_num_ready,
    output kvdp_pkg::t_num      o_num
);
    import kvdp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [INT_W-1:0]  r_int, n_int;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic              r_num_v;
    t_num              r_num;

    t_phase            cur_phase;
    logic [INT_W-1:0]  cur_int;
    logic [FRAC_W-1:0] cur_frac;
    logic [CNT_W-1:0]  cur_cnt;
    logic              cur_neg;
    logic              is_digit;
    logic [3:0]        digit;
    logic [ACC_W-1:0]  int_acc;
    logic [INT_W-1:0]  int_sat;
    logic              finish;
    logic              en;
    logic              accept;

    // output register free or draining
    assign en          = !r_num_v || i_num_ready;
    assign i_in.ready  = en;
    assign accept      = i_in.valid && en;
    assign o_num_valid = r_num_v;
    assign o_num       = r_num;

    always_comb begin
        // start of text clears the parse before the byte is handled
        cur_phase = i_in.start_of_text ? PH_SEEK_COLON : r_phase;
        cur_int   = i_in.start_of_text ? '0 : r_int;
        cur_frac  = i_in.start_of_text ? '0 : r_frac;
        cur_cnt   = i_in.start_of_text ? '0 : r_cnt;
        cur_neg   = i_in.start_of_text ? 1'b0 : r_neg;

        is_digit = (i_in.ch >= CHAR_ZERO) && (i_in.ch <= CHAR_NINE);
        digit    = 4'(i_in.ch - CHAR_ZERO);
        int_acc  = ACC_W'(cur_int) * ACC_W'(10) + ACC_W'(digit);
        int_sat  = (int_acc > ACC_W'(INT_LIMIT)) ? INT_LIMIT : int_acc[INT_W-1:0];

        n_phase = cur_phase;
        n_int   = cur_int;
        n_frac  = cur_frac;
        n_cnt   = cur_cnt;
        n_neg   = cur_neg;
        finish  = 1'b0;

        unique case (cur_phase)
            PH_SEEK_COLON: begin
                if (i_in.ch == CHAR_NUL) begin
                    finish = 1'b1;
                end else if (i_in.ch == CHAR_COLON) begin
                    n_phase = PH_SEEK_NUMBER;
                end
            end
            PH_SEEK_NUMBER: begin
                if (i_in.ch == CHAR_NUL) begin
                    finish = 1'b1;
                end else if (i_in.ch == CHAR_MINUS) begin
                    n_phase = PH_AFTER_MINUS;
                end else if (is_digit) begin
                    n_int   = int_sat;
                    n_phase = PH_INTEGER;
                end
            end
            PH_AFTER_MINUS: begin
                if (is_digit) begin
                    n_neg   = 1'b1;
                    n_int   = int_sat;
                    n_phase = PH_INTEGER;
                end else if (i_in.ch == CHAR_DOT) begin
                    n_phase = PH_FRACTION;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_INTEGER: begin
                if (is_digit) begin
                    n_int = int_sat;
                end else if (i_in.ch == CHAR_DOT) begin
                    n_phase = PH_FRACTION;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_FRACTION: begin
                if (is_digit && (cur_cnt < FRAC_MAX)) begin
                    n_frac = FRAC_W'(cur_frac * FRAC_W'(10)) + FRAC_W'(digit);
                    n_cnt  = cur_cnt + CNT_W'(1);
                end else begin
                    finish = 1'b1;
                end
            end
            PH_DONE: begin
                // bytes ignored until next text
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (finish) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK_COLON;
            r_int   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
            r_num_v <= 1'b0;
        end else if (en) begin
            r_num_v <= accept && finish;
            if (accept) begin
                r_phase <= n_phase;
                r_int   <= n_int;
                r_frac  <= n_frac;
                r_cnt   <= n_cnt;
                r_neg   <= n_neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && finish) begin
            r_num.int_part    <= cur_int;
            r_num.frac_digits <= cur_frac;
            r_num.frac_count  <= cur_cnt;
            r_num.negative    <= cur_neg;
        end
    end

endmodule

FILE: rtl/kvdp_scale.sv
// kvdp_scale: two-stage conversion of a parsed number to millionths
// (multiply stage, then signed sum into the result register).
// Depends on kvdp_pkg, kvdp_out_if.
module kvdp_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_num_valid,
    output logic                o_num_ready,
    input  kvdp_pkg::t_num      i_num,
    kvdp_out_if.source          o_out
);
    import kvdp_pkg::*;

    localparam int PI_W = INT_W + FRAC_W;   // 47 bits
    localparam int PF_W = FRAC_W + FRAC_W;  // 40 bits

    logic              r_mul_v;
    logic [PI_W-1:0]   r_prod_int;
    logic [PF_W-1:0]   r_prod_frac;
    logic              r_mul_neg;
    logic              r_out_v;
    logic [VALUE_W-1:0] r_value;

    logic              en_out;
    logic              en_mul;
    logic [VALUE_W-1:0] a_x;
    logic [VALUE_W-1:0] b_x;
    logic [VALUE_W-1:0] n_value;

    assign en_out      = !r_out_v || o_out.ready;
    assign en_mul      = !r_mul_v || en_out;
    assign o_num_ready = en_mul;

    // -(a+b) = ~a + ~b + 2
    always_comb begin
        a_x     = VALUE_W'(r_prod_int)  ^ {VALUE_W{r_mul_neg}};
        b_x     = VALUE_W'(r_prod_frac) ^ {VALUE_W{r_mul_neg}};
        n_value = a_x + b_x + (r_mul_neg ? VALUE_W'(2) : VALUE_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en_mul) begin
                r_mul_v <= i_num_valid;
            end
            if (en_out) begin
                r_out_v <= r_mul_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_mul && i_num_valid) begin
            r_prod_int  <= PI_W'(i_num.int_part) * PI_W'(MICRO);
            r_prod_frac <= PF_W'(i_num.frac_digits) * PF_W'(frac_scale(i_num.frac_count));
            r_mul_neg   <= i_num.negative;
        end
        if (en_out && r_mul_v) begin
            r_value <= n_value;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.value = r_value;

endmodule

FILE: test/kvdp_value_checker.sv
`timescale 1ns / 100ps
// kvdp_value_checker: watches both channels of the key/value decimal parser,
// predicts the value of each text and compares it with what comes out.
// Depends on kvdp_pkg.
module kvdp_value_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [kvdp_pkg::CH_W-1:0]           i_in_ch,
    input  logic                                i_in_sot,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [kvdp_pkg::VALUE_W-1:0] i_out_value,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import kvdp_pkg::*;

    localparam int DECIMALS = 6;    // value is in millionths

    // predicted parse state
    t_phase            ph;
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [CNT_W-1:0]  frac_cnt;
    logic              neg;

    logic signed [VALUE_W-1:0] value_q[$];
    logic signed [VALUE_W-1:0] want;
    int                        errors = 0;

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // shift in one integer digit, clamp at eight nines
    function automatic logic [INT_W-1:0] int_push(input logic [INT_W-1:0] acc,
                                                  input logic [CH_W-1:0] c);
        logic [31:0] v;
        v = 32'(acc) * 32'd10 + 32'(c - CHAR_ZERO);
        return (v > 32'(INT_LIMIT)) ? INT_LIMIT : v[INT_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] millionths();
        logic [63:0] weight;
        logic [63:0] mag;
        weight = 64'd1;
        for (int k = int'(frac_cnt); k < DECIMALS; k++)
            weight = weight * 64'd10;
        mag = 64'(int_acc) * 64'd1000000 + 64'(frac_acc) * weight;
        if (neg)
            mag = -mag;
        return mag[VALUE_W-1:0];
    endfunction

    task automatic clear_number();
        ph       = PH_SEEK_COLON;
        int_acc  = '0;
        frac_acc = '0;
        frac_cnt = '0;
        neg      = 1'b0;
    endtask

    task automatic fold_byte(input logic [CH_W-1:0] c, input logic sot);
        logic done;
        done = 1'b0;
        if (sot)
            clear_number();
        case (ph)
            PH_SEEK_COLON: begin
                if (c == CHAR_NUL)
                    done = 1'b1;
                else if (c == CHAR_COLON)
                    ph = PH_SEEK_NUMBER;
            end
            PH_SEEK_NUMBER: begin
                if (c == CHAR_NUL) begin
                    done = 1'b1;
                end else if (c == CHAR_MINUS) begin
                    ph = PH_AFTER_MINUS;
                end else if (is_digit(c)) begin
                    int_acc = int_push(int_acc, c);
                    ph      = PH_INTEGER;
                end
            end
            PH_AFTER_MINUS: begin
                // sign only sticks when a digit follows it
                if (is_digit(c)) begin
                    neg     = 1'b1;
                    int_acc = int_push(int_acc, c);
                    ph      = PH_INTEGER;
                end else if (c == CHAR_DOT) begin
                    ph = PH_FRACTION;
                end else begin
                    done = 1'b1;
                end
            end
            PH_INTEGER: begin
                if (is_digit(c))
                    int_acc = int_push(int_acc, c);
                else if (c == CHAR_DOT)
                    ph = PH_FRACTION;
                else
                    done = 1'b1;
            end
            PH_FRACTION: begin
                if (is_digit(c) && (frac_cnt < CNT_W'(MAX_FRACTION_DIGITS))) begin
                    frac_acc = frac_acc * FRAC_W'(10) + FRAC_W'(c - CHAR_ZERO);
                    frac_cnt = frac_cnt + CNT_W'(1);
                end else begin
                    done = 1'b1;
                end
            end
            default: ;  // done: ignore until next start of text
        endcase
        if (done) begin
            value_q.push_back(millionths());
            ph = PH_DONE;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_number();
            value_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (value_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %0d",
                             $time, i_out_value);
                end else begin
                    want = value_q.pop_front();
                    if (i_out_value !== want) begin
                        errors++;
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want, i_out_value);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                fold_byte(i_in_ch, i_in_sot);
        end
        o_fail_count <= errors;
        o_pending    <= value_q.size();
    end

endmodule

FILE: test/tb_key_value_decimal_parser_core.sv
`timescale 1ns / 100ps
// tb_key_value_decimal_parser_core: stimulus and verdict for the key/value
// decimal parser. Depends on kvdp_pkg, both channel interfaces, the core and
// kvdp_value_checker.
module tb_key_value_decimal_parser_core;
    import kvdp_pkg::*;

    localparam int RANDOM_ITEMS = 500;   // bytes in the random part
    localparam int HOLD_CYCLES  = 60;    // long receiver stall for back-pressure
    localparam int DRAIN_CYCLES = 8;     // pipeline is three deep
    localparam int IDLE_LIMIT   = 3000;  // cycles with no transaction at all

    logic clk;
    logic rst_n;

    kvdp_in_if  in_ch ();
    kvdp_out_if out_ch ();

    int fail_count;
    int pending;

    key_value_decimal_parser_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    kvdp_value_checker checker_u (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_ch      (in_ch.ch),
        .i_in_sot     (in_ch.start_of_text),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_value  (out_ch.value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Receiver: random runs of ready high/low, now and then a long run
    // with no stall at all. A hold request from the stimulus side makes
    // it hold ready low so the three stages fill and the input side
    // has to stall.
    // ------------------------------------------------------------------
    int   holds_asked = 0;
    int   holds_done  = 0;
    int   hold_left   = 0;
    int   ready_run   = 0;
    logic ready_level = 1'b1;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else begin
            if (ready_run == 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        ready_level = 1'b1;
                        ready_run   = $urandom_range(100, 200);
                    end
                    1, 2, 3: begin
                        ready_level = 1'b0;
                        ready_run   = $urandom_range(1, 12);
                    end
                    default: begin
                        ready_level = 1'b1;
                        ready_run   = $urandom_range(1, 15);
                    end
                endcase
            end
            ready_run--;
            out_ch.ready <= ready_level;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any stretch this long without a transaction on either
    // channel means the block is hung.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. Bytes go out in bursts of random length; between bursts
    // valid drops for a random gap. 'steady' turns the gaps off.
    // 'offering' mirrors what valid was last set to, since the NBA value
    // is not visible in the step that scheduled it.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] text_buf[$];
    logic            noise_sot  = 1'b0;
    logic            steady     = 1'b0;
    logic            offering   = 1'b0;
    int              burst_left = 1;
    int              bytes_sent = 0;

    // Called at a rising edge; returns at the edge the byte was taken
    // (or after the gap that follows it).
    task automatic send_byte(input logic [CH_W-1:0] c, input logic sot);
        int gap;
        in_ch.valid         <= 1'b1;
        in_ch.ch            <= c;
        in_ch.start_of_text <= sot;
        offering = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // First byte of the buffer always opens a new text; noise texts may
    // also raise start_of_text in the middle.
    task automatic send_text();
        foreach (text_buf[k])
            send_byte(text_buf[k],
                      (k == 0) || (noise_sot && ($urandom_range(0, 3) == 0)));
    endtask

    task automatic put_str(input string s);
        for (int k = 0; k < s.len(); k++)
            text_buf.push_back(s[k]);
    endtask

    task automatic put_digits(input int n);
        repeat (n) text_buf.push_back(CHAR_ZERO + CH_W'($urandom_range(0, 9)));
    endtask

    // Directed text: string, then optionally a NUL terminator.
    task automatic send_literal(input string s, input logic with_nul);
        text_buf.delete();
        put_str(s);
        if (with_nul)
            text_buf.push_back(CHAR_NUL);
        send_text();
    endtask

    // Mostly well-formed "key:number<end>" texts with random content;
    // the rest is raw noise, missing colons and texts left unfinished.
    task automatic build_random_text();
        int              kind;
        int              n;
        logic [CH_W-1:0] c;
        string           fill;
        fill = " +=\"x";
        text_buf.delete();
        noise_sot = 1'b0;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            noise_sot = 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) text_buf.push_back(CH_W'($urandom_range(0, 255)));
        end else begin
            // key: any non-NUL byte but the colon
            repeat ($urandom_range(0, 4)) begin
                do c = CH_W'($urandom_range(1, 255)); while (c == CHAR_COLON);
                text_buf.push_back(c);
            end
            if (kind != 2)
                text_buf.push_back(CHAR_COLON);
            repeat ($urandom_range(0, 2))
                text_buf.push_back(fill[$urandom_range(0, 4)]);
            if ($urandom_range(0, 2) == 0)
                text_buf.push_back(CHAR_MINUS);
            // a few long integers to hit the clamp
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 6);
            put_digits(n);
            if ($urandom_range(0, 2) != 0) begin
                text_buf.push_back(CHAR_DOT);
                put_digits($urandom_range(0, 7));
            end
            case ($urandom_range(0, 9))
                0: ;    // no end: dropped by the next start of text
                1, 2, 3, 4: begin
                    do c = CH_W'($urandom_range(1, 255));
                    while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT);
                    text_buf.push_back(c);
                end
                default: text_buf.push_back(CHAR_NUL);
            endcase
            // junk after the end is ignored by the block
            repeat ($urandom_range(0, 2))
                text_buf.push_back(CH_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int base;
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.ch            <= '0;
        in_ch.start_of_text <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // -------- directed texts --------
        send_literal("", 1'b1);                   // NUL before any colon
        send_literal("id:", 1'b1);                // colon, then nothing
        send_literal("a:+5", 1'b1);               // plus is just skipped
        send_literal("b:-x", 1'b0);               // lone minus, then other byte
        send_literal("c:-.5", 1'b1);              // minus then dot: positive fraction
        send_literal("d:7.", 1'b1);               // dot without digits
        send_literal("e:999999999", 1'b1);        // integer clamp
        send_literal("f:1.1234567", 1'b0);        // seventh fraction digit ends it
        send_literal("g:-0", 1'b1);               // negative zero
        send_literal("h:-99999999.999999", 1'b1); // most negative value
        send_literal("w:99999999.999999", 1'b1);  // most positive value
        send_literal("k:.5", 1'b1);               // dot before number is skipped
        send_literal("m:--7", 1'b1);              // second minus ends the number
        send_literal(":5", 1'b0);                 // unfinished, dropped
        send_literal("q: 3", 1'b1);
        // all-ones byte skipped while seeking, then junk after the end
        text_buf.delete();
        text_buf.push_back(CHAR_COLON);
        text_buf.push_back(8'hFF);
        put_str("12");
        text_buf.push_back(CHAR_NUL);
        put_str("34:5");
        send_text();

        // -------- back-pressure: receiver holds off, sender keeps going --------
        holds_asked++;
        steady = 1'b1;
        repeat (8) send_literal(":1", 1'b1);
        steady = 1'b0;

        // -------- random texts --------
        base = bytes_sent;
        while (bytes_sent - base < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 7) == 0);
            build_random_text();
            send_text();
        end

        if (offering)
            in_ch.valid <= 1'b0;

        // drain; the watchdog covers a hang here
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
